// File: hw/rtl/pei_pkg.sv
// ----------------------------------------------------------------------------
// pei_pkg
// Shared types, constants and helpers of the particle Euler integrator.
// ----------------------------------------------------------------------------
package pei_pkg;

    // fixed-point format and damping table size
    localparam int FRAC_BITS      = 16;
    localparam int EXP_TABLE_BITS = 8;

    localparam int NUM_LANES  = 3;
    localparam int WORD_W     = 32;
    localparam int DT_W       = 31;
    localparam int DAMP_W     = 24;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 288;
    localparam int ADDR_W     = 5;
    localparam int REG_IDX_W  = 3;

    // damping exponent: dt * log2(damping), 2*FRAC_BITS fraction bits
    localparam int E_W       = DT_W + 1 + DAMP_W;
    localparam int NW        = E_W - 2 * FRAC_BITS;
    localparam int FACTOR_W  = FRAC_BITS + 1;
    localparam int JW        = (EXP_TABLE_BITS > 1) ? $clog2(EXP_TABLE_BITS) : 1;
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;

    typedef enum logic [1:0] {
        OP_ADD_FORCE = 2'd0,
        OP_INTEGRATE = 2'd1,
        OP_LOAD_POS  = 2'd2,
        OP_LOAD_VEL  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_STATIC = 2'd1,
        STS_BAD_DT = 2'd2,
        STS_SAT    = 2'd3
    } t_status;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_INV_MASS  = 3'd0,
        REG_DAMP_LOG2 = 3'd1,
        REG_ACCEL_X   = 3'd2,
        REG_ACCEL_Y   = 3'd3,
        REG_ACCEL_Z   = 3'd4
    } t_reg_idx;

    // lane multiplier operand A
    typedef enum logic [1:0] {
        A_VEL,
        A_FORCE,
        A_ACC
    } t_asel;

    // lane adder destination (also picks the addend)
    typedef enum logic [2:0] {
        D_POS,
        D_ACC,
        D_VEL,
        D_VSCALE,
        D_NET
    } t_dst;

    // lane state load / update
    typedef enum logic [2:0] {
        LD_NONE,
        LD_FORCE_ADD,
        LD_POS,
        LD_VEL,
        LD_CLR_FORCE
    } t_ld;

    typedef struct packed {
        logic  mul_en;
        t_asel a_sel;
        logic  add_en;
        t_dst  dst;
        t_ld   ld;
    } t_lane_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPLY,
        ST_VDT,
        ST_POS_FM,
        ST_ACC,
        ST_ADT,
        ST_VEL,
        ST_DAMP,
        ST_SCALE,
        ST_NET_MUL,
        ST_NET_ADD,
        ST_PUSH
    } t_ctl_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_ITER,
        D_SHIFT
    } t_damp_state;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] val;
    } t_sat;

    typedef logic [EXP_TABLE_BITS-1:0][31:0] t_root_tab;

    function automatic t_sat sat32(input logic signed [63:0] v);
        t_sat r;
        if (v > 64'sd2147483647) begin
            r.hit = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r.hit = 1'b1;
            r.val = 32'sh8000_0000;
        end else begin
            r.hit = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

    // floor square root, elaboration use only
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        int          k;
        v = x;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (k = 0; k < 32; k++) begin
            if (b > v) b = b >> 2;
        end
        for (k = 0; k < 32; k++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Q2.30 roots 2^(2^-j), j = 1 .. EXP_TABLE_BITS, entry j-1
    function automatic t_root_tab make_roots();
        t_root_tab   tab;
        logic [63:0] root;
        int          j;
        root = 64'h8000_0000;
        for (j = 0; j < EXP_TABLE_BITS; j++) begin
            root   = isqrt64(root << 30);
            tab[j] = root[31:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOTS = make_roots();

endpackage

// File: hw/rtl/particle_euler_integrator_top.sv
// ----------------------------------------------------------------------------
// particle_euler_integrator_top
// Single-particle Euler integrator with damping, Q16.16, three parallel lanes.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream: one item per operation; tuser carries the opcode (add
//    force, integrate, load position, load velocity), tdata the vector and
//    the step time. The block takes one item at a time.
//  - Output stream: exactly one result item per input item: position,
//    velocity and net acceleration, plus a status code in tuser.
//  - Steps: add force and loads go through apply, force multiply, net add
//    and push; a skipped integrate leaves out apply. A full integrate runs
//    the lane steps while the damping unit walks the eight root-table
//    multiplies one per cycle; the lanes wait on it before the velocity scale.
//  - Overlap: a new item is taken only after the last result is pushed.
//  - Stall: the result sits in an output register; the sequencer holds in its
//    push step until that register is free, and input tready stays low.
//  - Reset: state vectors, config registers and the handshake control clear
//    synchronously; the block is ready in the first cycle after reset.
//  - Config: APB writes, which the user must make only while the block is idle (not enforced); pready is tied high.
// ----------------------------------------------------------------------------
module particle_euler_integrator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: vec_x[31:0], vec_y[63:32], vec_z[95:64], step_time[126:96], 0
    input  logic [pei_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]                         i_s_tuser,
    // output stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    //        net_accel_x, net_accel_y, net_accel_z; 32 bits each from bit 0
    output logic [pei_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // tuser: status[1:0]
    output logic [1:0]                         o_m_tuser,
    // config port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pei_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int NL = pei_pkg::NUM_LANES;

    // config registers
    logic [pei_pkg::DT_W-1:0]           r_inv_mass;
    logic signed [pei_pkg::DAMP_W-1:0]  r_damp_log2;
    logic signed [31:0]                 r_base [NL];

    // item registers
    pei_pkg::t_ctl_state  r_state;
    pei_pkg::t_ctl_state  n_state;
    pei_pkg::t_opcode     r_op;
    logic signed [31:0]   r_vec [NL];
    logic [pei_pkg::DT_W-1:0] r_dt;
    pei_pkg::t_status     r_code;
    pei_pkg::t_status     n_code;

    logic                 accept;
    logic                 cfg_wr;
    pei_pkg::t_reg_idx    reg_idx;
    pei_pkg::t_opcode     in_op;
    logic [pei_pkg::DT_W-1:0] in_dt;
    logic                 in_skip;

    pei_pkg::t_lane_ctl   lane_ctl;
    logic [30:0]          mul_b;
    logic                 damp_start;
    logic                 damp_done;
    logic [pei_pkg::FACTOR_W-1:0] damp_factor;
    logic                 push;
    logic                 out_room;

    logic [NL-1:0]        lane_sat;
    logic [NL-1:0][31:0]  lane_pos;
    logic [NL-1:0][31:0]  lane_vel;
    logic [NL-1:0][31:0]  lane_net;

    assign o_s_tready = (r_state == pei_pkg::ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_op      = pei_pkg::t_opcode'(i_s_tuser);
    assign in_dt      = i_s_tdata[126:96];
    // static body or zero duration: state stays, only the net accel is formed
    assign in_skip    = (r_inv_mass == '0) || (in_dt == '0);

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = pei_pkg::t_reg_idx'(paddr[pei_pkg::ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass  <= '0;
            r_damp_log2 <= '0;
            for (int k = 0; k < NL; k++) r_base[k] <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                pei_pkg::REG_INV_MASS:  r_inv_mass  <= pwdata[pei_pkg::DT_W-1:0];
                pei_pkg::REG_DAMP_LOG2: r_damp_log2 <= pwdata[pei_pkg::DAMP_W-1:0];
                pei_pkg::REG_ACCEL_X:   r_base[0]   <= pwdata;
                pei_pkg::REG_ACCEL_Y:   r_base[1]   <= pwdata;
                pei_pkg::REG_ACCEL_Z:   r_base[2]   <= pwdata;
                default: ;   // unused addresses ignored
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pei_pkg::REG_INV_MASS:  prdata = {1'b0, r_inv_mass};
            pei_pkg::REG_DAMP_LOG2: prdata = 32'(r_damp_log2);
            pei_pkg::REG_ACCEL_X:   prdata = r_base[0];
            pei_pkg::REG_ACCEL_Y:   prdata = r_base[1];
            pei_pkg::REG_ACCEL_Z:   prdata = r_base[2];
            default:                prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pei_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_op != pei_pkg::OP_INTEGRATE) n_state = pei_pkg::ST_APPLY;
                    else if (in_skip)                   n_state = pei_pkg::ST_NET_MUL;
                    else                                n_state = pei_pkg::ST_VDT;
                end
            end
            pei_pkg::ST_APPLY:   n_state = pei_pkg::ST_NET_MUL;
            pei_pkg::ST_VDT:     n_state = pei_pkg::ST_POS_FM;
            pei_pkg::ST_POS_FM:  n_state = pei_pkg::ST_ACC;
            pei_pkg::ST_ACC:     n_state = pei_pkg::ST_ADT;
            pei_pkg::ST_ADT:     n_state = pei_pkg::ST_VEL;
            pei_pkg::ST_VEL:     n_state = pei_pkg::ST_DAMP;
            pei_pkg::ST_DAMP:    if (damp_done) n_state = pei_pkg::ST_SCALE;
            pei_pkg::ST_SCALE:   n_state = pei_pkg::ST_NET_MUL;
            pei_pkg::ST_NET_MUL: n_state = pei_pkg::ST_NET_ADD;
            pei_pkg::ST_NET_ADD: n_state = pei_pkg::ST_PUSH;
            pei_pkg::ST_PUSH:    if (out_room) n_state = pei_pkg::ST_IDLE;
            default:             n_state = pei_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (in_op != pei_pkg::OP_INTEGRATE) n_code = pei_pkg::STS_OK;
        else if (r_inv_mass == '0)          n_code = pei_pkg::STS_STATIC;
        else if (in_dt == '0)               n_code = pei_pkg::STS_BAD_DT;
        else                                n_code = pei_pkg::STS_OK;
    end

    // lane commands per step
    always_comb begin
        lane_ctl.mul_en = 1'b0;
        lane_ctl.a_sel  = pei_pkg::A_VEL;
        lane_ctl.add_en = 1'b0;
        lane_ctl.dst    = pei_pkg::D_POS;
        lane_ctl.ld     = pei_pkg::LD_NONE;
        mul_b           = r_dt;
        damp_start      = 1'b0;
        push            = 1'b0;
        unique case (r_state)
            pei_pkg::ST_IDLE: begin
                damp_start = accept && (in_op == pei_pkg::OP_INTEGRATE) && !in_skip;
            end
            pei_pkg::ST_APPLY: begin
                unique case (r_op)
                    pei_pkg::OP_ADD_FORCE: lane_ctl.ld = pei_pkg::LD_FORCE_ADD;
                    pei_pkg::OP_LOAD_POS:  lane_ctl.ld = pei_pkg::LD_POS;
                    pei_pkg::OP_LOAD_VEL:  lane_ctl.ld = pei_pkg::LD_VEL;
                    default:               lane_ctl.ld = pei_pkg::LD_NONE;
                endcase
            end
            pei_pkg::ST_VDT: begin
                lane_ctl.mul_en = 1'b1;           // vel * dt
            end
            pei_pkg::ST_POS_FM: begin
                lane_ctl.add_en = 1'b1;           // pos += vel*dt
                lane_ctl.dst    = pei_pkg::D_POS;
                lane_ctl.mul_en = 1'b1;           // force * inv_mass
                lane_ctl.a_sel  = pei_pkg::A_FORCE;
                mul_b           = r_inv_mass;
            end
            pei_pkg::ST_ACC: begin
                lane_ctl.add_en = 1'b1;
                lane_ctl.dst    = pei_pkg::D_ACC;
            end
            pei_pkg::ST_ADT: begin
                lane_ctl.mul_en = 1'b1;           // acc * dt
                lane_ctl.a_sel  = pei_pkg::A_ACC;
            end
            pei_pkg::ST_VEL: begin
                lane_ctl.add_en = 1'b1;
                lane_ctl.dst    = pei_pkg::D_VEL;
            end
            pei_pkg::ST_DAMP: begin
                lane_ctl.mul_en = damp_done;      // vel * factor
                mul_b           = 31'(damp_factor);
            end
            pei_pkg::ST_SCALE: begin
                lane_ctl.add_en = 1'b1;
                lane_ctl.dst    = pei_pkg::D_VSCALE;
                lane_ctl.ld     = pei_pkg::LD_CLR_FORCE;
            end
            pei_pkg::ST_NET_MUL: begin
                lane_ctl.mul_en = 1'b1;
                lane_ctl.a_sel  = pei_pkg::A_FORCE;
                mul_b           = r_inv_mass;
            end
            pei_pkg::ST_NET_ADD: begin
                lane_ctl.add_en = 1'b1;
                lane_ctl.dst    = pei_pkg::D_NET;
            end
            pei_pkg::ST_PUSH: begin
                push = out_room;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= pei_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= in_op;
            r_dt     <= in_dt;
            r_code   <= n_code;
            r_vec[0] <= i_s_tdata[31:0];
            r_vec[1] <= i_s_tdata[63:32];
            r_vec[2] <= i_s_tdata[95:64];
        end
    end

    // ---------------- lanes ----------------
    for (genvar g = 0; g < NL; g++) begin : g_lane
        pei_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_vec   (r_vec[g]),
            .i_base  (r_base[g]),
            .i_mul_b (mul_b),
            .o_pos   (lane_pos[g]),
            .o_vel   (lane_vel[g]),
            .o_net   (lane_net[g]),
            .o_sat   (lane_sat[g])
        );
    end

    pei_damp u_damp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (damp_start),
        .i_dt     (in_dt),
        .i_dlog   (r_damp_log2),
        .o_done   (damp_done),
        .o_factor (damp_factor)
    );

    pei_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (accept),
        .i_lane_sat (lane_sat),
        .i_code     (r_code),
        .i_load     (push),
        .i_pos      (lane_pos),
        .i_vel      (lane_vel),
        .i_net      (lane_net),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_room     (out_room)
    );

endmodule

// File: hw/rtl/pei_lane.sv
// ----------------------------------------------------------------------------
// pei_lane
// One vector component: position, velocity and force state with one multiplier,
// a saturating adder and a saturating force adder, driven step by step by the sequencer.
// ----------------------------------------------------------------------------
module pei_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pei_pkg::t_lane_ctl  i_ctl,
    input  logic signed [31:0]  i_vec,
    input  logic signed [31:0]  i_base,
    input  logic [30:0]         i_mul_b,
    output logic signed [31:0]  o_pos,
    output logic signed [31:0]  o_vel,
    output logic signed [31:0]  o_net,
    output logic                o_sat
);

    logic signed [31:0] r_pos;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_force;
    logic signed [31:0] r_acc;
    logic signed [31:0] r_net;
    logic signed [63:0] r_prod;

    logic signed [31:0] mul_a;
    logic signed [63:0] mul_p;
    logic signed [63:0] addend;
    logic signed [63:0] shifted;
    pei_pkg::t_sat      add_res;
    pei_pkg::t_sat      force_res;

    always_comb begin
        case (i_ctl.a_sel)
            pei_pkg::A_FORCE: mul_a = r_force;
            pei_pkg::A_ACC:   mul_a = r_acc;
            default:          mul_a = r_vel;
        endcase
    end

    // B is never negative
    assign mul_p = mul_a * $signed({1'b0, i_mul_b});

    always_comb begin
        case (i_ctl.dst)
            pei_pkg::D_POS:    addend = 64'(r_pos);
            pei_pkg::D_VEL:    addend = 64'(r_vel);
            pei_pkg::D_VSCALE: addend = 64'sd0;
            default:           addend = 64'(i_base);
        endcase
    end

    // arithmetic shift = floor
    assign shifted   = r_prod >>> pei_pkg::FRAC_BITS;
    assign add_res   = pei_pkg::sat32(addend + shifted);
    assign force_res = pei_pkg::sat32(64'(r_force) + 64'(i_vec));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_vel   <= '0;
            r_force <= '0;
        end else begin
            if (i_ctl.add_en) begin
                case (i_ctl.dst)
                    pei_pkg::D_POS:    r_pos <= add_res.val;
                    pei_pkg::D_VEL:    r_vel <= add_res.val;
                    pei_pkg::D_VSCALE: r_vel <= add_res.val;
                    default: ;
                endcase
            end
            case (i_ctl.ld)
                pei_pkg::LD_FORCE_ADD: r_force <= force_res.val;
                pei_pkg::LD_POS:       r_pos   <= i_vec;
                pei_pkg::LD_VEL:       r_vel   <= i_vec;
                pei_pkg::LD_CLR_FORCE: r_force <= '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) r_prod <= mul_p;
        if (i_ctl.add_en && i_ctl.dst == pei_pkg::D_ACC) r_acc <= add_res.val;
        if (i_ctl.add_en && i_ctl.dst == pei_pkg::D_NET) r_net <= add_res.val;
    end

    assign o_pos = r_pos;
    assign o_vel = r_vel;
    assign o_net = r_net;
    assign o_sat = (i_ctl.add_en & add_res.hit)
                 | ((i_ctl.ld == pei_pkg::LD_FORCE_ADD) & force_res.hit);

endmodule

// File: hw/rtl/pei_damp.sv
// ----------------------------------------------------------------------------
// pei_damp
// Damping factor 2^(dt * log2 damping): exponent multiply, one conditional table root
// multiply for each of the top EXP_TABLE_BITS fraction bits, then the integer-part shift.
// ----------------------------------------------------------------------------
module pei_damp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [pei_pkg::DT_W-1:0]            i_dt,
    input  logic signed [pei_pkg::DAMP_W-1:0]   i_dlog,
    output logic                                o_done,
    output logic [pei_pkg::FACTOR_W-1:0]        o_factor
);

    localparam logic [pei_pkg::JW-1:0] J_LAST = pei_pkg::JW'(pei_pkg::EXP_TABLE_BITS - 1);
    localparam int                     SH_MIN = 30 - pei_pkg::FRAC_BITS;

    pei_pkg::t_damp_state r_state;
    pei_pkg::t_damp_state n_state;

    logic [pei_pkg::DT_W-1:0]           r_dt;
    logic signed [pei_pkg::DAMP_W-1:0]  r_d;
    logic                               r_zero;
    logic signed [pei_pkg::E_W-1:0]     r_e;
    logic [31:0]                        r_m;
    logic [pei_pkg::JW-1:0]             r_j;
    logic [pei_pkg::FACTOR_W-1:0]       r_factor;

    logic                               do_mul;
    logic                               do_iter;
    logic                               do_shift;

    logic [pei_pkg::EXP_TABLE_BITS-1:0] idx;
    logic [63:0]                        m_prod;
    logic signed [pei_pkg::NW-1:0]      e_int;
    logic [pei_pkg::NW-1:0]             nn;
    logic [5:0]                         sh;
    logic [31:0]                        m_shr;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pei_pkg::D_IDLE:  if (i_start) n_state = pei_pkg::D_MUL;
            pei_pkg::D_MUL:   n_state = pei_pkg::D_ITER;
            pei_pkg::D_ITER:  if (r_j == J_LAST) n_state = pei_pkg::D_SHIFT;
            pei_pkg::D_SHIFT: n_state = pei_pkg::D_IDLE;
            default:          n_state = pei_pkg::D_IDLE;
        endcase
    end

    always_comb begin
        do_mul   = (r_state == pei_pkg::D_MUL);
        do_iter  = (r_state == pei_pkg::D_ITER);
        do_shift = (r_state == pei_pkg::D_SHIFT);
        o_done   = (r_state == pei_pkg::D_IDLE);
    end

    assign idx    = r_e[2*pei_pkg::FRAC_BITS-1 -: pei_pkg::EXP_TABLE_BITS];
    assign m_prod = r_m * pei_pkg::ROOTS[r_j];
    assign e_int  = r_e[pei_pkg::E_W-1 -: pei_pkg::NW];
    assign nn     = -e_int;
    assign sh     = 6'(SH_MIN) + nn[5:0];
    assign m_shr  = r_m >> sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pei_pkg::D_IDLE;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (do_iter) r_j <= r_j + 1'b1;
            else         r_j <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dt   <= i_dt;
            // most negative code means damping zero; positive logs clamp to 1.0
            r_zero <= (i_dlog == {1'b1, {(pei_pkg::DAMP_W-1){1'b0}}});
            r_d    <= (i_dlog > 0) ? '0 : i_dlog;
            r_m    <= pei_pkg::Q30_ONE;
        end
        if (do_mul) r_e <= $signed({1'b0, r_dt}) * r_d;
        if (do_iter && idx[J_LAST - r_j]) r_m <= m_prod[61:30];
        if (do_shift) begin
            if (r_zero || nn >= pei_pkg::NW'(pei_pkg::FRAC_BITS + 2)) r_factor <= '0;
            else r_factor <= m_shr[pei_pkg::FACTOR_W-1:0];
        end
    end

    assign o_factor = r_factor;

endmodule

// File: hw/rtl/pei_merge.sv
// ----------------------------------------------------------------------------
// pei_merge
// Folds the lane saturation flags into the item status and holds the
// result item in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module pei_merge (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_clr,
    input  logic [pei_pkg::NUM_LANES-1:0]                 i_lane_sat,
    input  pei_pkg::t_status                              i_code,
    input  logic                                          i_load,
    input  logic [pei_pkg::NUM_LANES-1:0][31:0]           i_pos,
    input  logic [pei_pkg::NUM_LANES-1:0][31:0]           i_vel,
    input  logic [pei_pkg::NUM_LANES-1:0][31:0]           i_net,
    input  logic                                          i_m_tready,
    output logic                                          o_m_tvalid,
    output logic [pei_pkg::OUT_DATA_W-1:0]                o_m_tdata,
    output logic [1:0]                                    o_m_tuser,
    output logic                                          o_room
);

    logic                            r_sat;
    logic                            r_valid;
    logic [pei_pkg::OUT_DATA_W-1:0]  r_data;
    pei_pkg::t_status                r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_clr) r_sat <= 1'b0;
            else       r_sat <= r_sat | (|i_lane_sat);
            if (i_load)          r_valid <= 1'b1;
            else if (i_m_tready) r_valid <= 1'b0;
        end
    end

    // skip and bad-duration codes win over saturation
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= {i_net, i_vel, i_pos};
            if (i_code != pei_pkg::STS_OK) r_status <= i_code;
            else if (r_sat)                r_status <= pei_pkg::STS_SAT;
            else                           r_status <= pei_pkg::STS_OK;
        end
    end

    assign o_room     = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_status;

endmodule

// File: hw/rtl/pei_checker.sv
// ----------------------------------------------------------------------------
// pei_checker
// Port-level checks of the integrator handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module pei_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [pei_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input logic [1:0]                      o_m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // one item in flight: ready drops after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while an item is in flight");

    // a new result only comes out of a busy sequencer, which then frees up
    a_push_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready) && o_s_tready)
        else $error("result appeared without an item in flight");

endmodule

bind particle_euler_integrator_top pei_checker u_pei_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the particle Euler integrator. A queued driver
// feeds operation items into the input stream while a monitor checks every
// result item against an in-bench particle model. The APB port reprograms
// mass, damping and base acceleration between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int QUIET_LIMIT   = 3000;  // cycles with no progress before giving up
    localparam int SETTLE_CYCLES = 24;    // longer than a full integrate
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 125;
    localparam int REG_SPARE_LO  = 5;     // first index with no register behind it
    localparam int REG_SPARE_HI  = (1 << pei_pkg::REG_IDX_W) - 1;

    // one operation item
    typedef struct packed {
        pei_pkg::t_opcode         op;
        logic [pei_pkg::DT_W-1:0] dt;
        logic [2:0][31:0]         vec;
    } t_motion_cmd;

    // one result item: words 0-2 position, 3-5 velocity, 6-8 net acceleration
    typedef struct packed {
        logic [8:0][31:0] words;
        pei_pkg::t_status status;
    } t_state_report;

    // ------------------------------------------------------------------------
    // clock, reset and all block inputs, known from time zero
    // ------------------------------------------------------------------------
    logic                           i_clk;
    logic                           i_rst_n   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic [pei_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]                     s_tuser   = '0;
    logic                           m_tready  = 1'b0;
    logic                           psel_r    = 1'b0;
    logic                           penable_r = 1'b0;
    logic                           pwrite_r  = 1'b0;
    logic [pei_pkg::ADDR_W-1:0]     paddr_r   = '0;
    logic [31:0]                    pwdata_r  = '0;

    logic                           o_s_tready;
    logic                           o_m_tvalid;
    logic [pei_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic [1:0]                     o_m_tuser;
    logic [31:0]                    prdata;
    logic                           pready;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    particle_euler_integrator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),      // vec_x, vec_y, vec_z, step_time, 0 from bit 0
        .i_s_tuser  (s_tuser),      // opcode
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),    // pos xyz, vel xyz, net accel xyz from bit 0
        .o_m_tuser  (o_m_tuser),    // status
        .psel       (psel_r),
        .penable    (penable_r),
        .pwrite     (pwrite_r),
        .paddr      (paddr_r),
        .pwdata     (pwdata_r),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------------
    // particle model: shadow registers and state
    // ------------------------------------------------------------------------
    logic [pei_pkg::DT_W-1:0]          inv_mass_r = '0;
    logic signed [pei_pkg::DAMP_W-1:0] damp_r     = '0;
    logic signed [31:0]       accel_r [3];
    logic signed [31:0]       pos_st  [3];
    logic signed [31:0]       vel_st  [3];
    logic signed [31:0]       frc_st  [3];
    logic [63:0]              root_tab [pei_pkg::EXP_TABLE_BITS];
    bit                       sat_seen;

    t_motion_cmd   cmd_backlog[$];        // items waiting for the driver
    t_state_report state_reports_due[$];  // predicted results, oldest first

    int cmds_sent    = 0;
    int cmds_taken   = 0;
    int results_seen = 0;
    int err_cnt      = 0;
    int settings_cnt = 0;
    int src_gap_pct  = 0;
    int snk_gap_pct  = 0;
    int quiet_cycles = 0;

    string word_names [9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                              "net_accel_x", "net_accel_y", "net_accel_z"};

    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        int          b;
        r = '0;
        for (b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            sat_seen = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat_seen = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // 2^(dt * d) with FRAC_BITS fraction bits, built from the root table
    function automatic longint damp_gain(input logic [pei_pkg::DT_W-1:0] dt,
                                         input logic signed [pei_pkg::DAMP_W-1:0] d);
        longint      dd;
        longint      dtl;
        longint      e;
        longint      n;
        logic [63:0] fr;
        logic [63:0] sel;
        logic [63:0] m;
        logic [63:0] shamt;
        int          j;
        dd = d;
        dtl = dt;
        if (dd <= -64'sd8388608) return 0;   // fully damped
        if (dd > 0) dd = 0;                  // positive log clips to no damping
        e     = dtl * dd;
        n     = e >>> (2 * pei_pkg::FRAC_BITS);
        fr    = 64'(e) & ((64'd1 << (2 * pei_pkg::FRAC_BITS)) - 64'd1);
        sel   = fr >> (2 * pei_pkg::FRAC_BITS - pei_pkg::EXP_TABLE_BITS);
        m     = 64'd1 << 30;
        for (j = 1; j <= pei_pkg::EXP_TABLE_BITS; j++) begin
            if ((sel >> (pei_pkg::EXP_TABLE_BITS - j)) & 64'd1)
                m = (m * root_tab[j-1]) >> 30;
        end
        shamt = 64'(30 - pei_pkg::FRAC_BITS) + 64'(-n);
        if (shamt >= 64'd63) return 0;
        return longint'(m >> shamt);
    endfunction

    function automatic t_state_report predict_motion(input t_motion_cmd c);
        t_state_report      r;
        pei_pkg::t_status   st;
        longint             g;
        longint             dtl;
        longint             iml;
        logic signed [31:0] acc;
        int                 i;
        sat_seen = 1'b0;
        st  = pei_pkg::STS_OK;
        dtl = c.dt;
        iml = inv_mass_r;
        case (c.op)
            pei_pkg::OP_ADD_FORCE: begin
                for (i = 0; i < 3; i++)
                    frc_st[i] = clamp32(longint'(frc_st[i]) + longint'($signed(c.vec[i])));
            end
            pei_pkg::OP_LOAD_POS: begin
                for (i = 0; i < 3; i++) pos_st[i] = c.vec[i];
            end
            pei_pkg::OP_LOAD_VEL: begin
                for (i = 0; i < 3; i++) vel_st[i] = c.vec[i];
            end
            default: begin
                if (inv_mass_r == '0) begin
                    st = pei_pkg::STS_STATIC;
                end else if (c.dt == '0) begin
                    st = pei_pkg::STS_BAD_DT;
                end else begin
                    g = damp_gain(c.dt, damp_r);
                    for (i = 0; i < 3; i++) begin
                        pos_st[i] = clamp32(longint'(pos_st[i]) +
                            ((longint'(vel_st[i]) * dtl) >>> pei_pkg::FRAC_BITS));
                        acc       = clamp32(longint'(accel_r[i]) +
                            ((longint'(frc_st[i]) * iml) >>> pei_pkg::FRAC_BITS));
                        vel_st[i] = clamp32(longint'(vel_st[i]) +
                            ((longint'(acc) * dtl) >>> pei_pkg::FRAC_BITS));
                        vel_st[i] = clamp32((longint'(vel_st[i]) * g) >>> pei_pkg::FRAC_BITS);
                        frc_st[i] = '0;
                    end
                end
            end
        endcase
        for (i = 0; i < 3; i++) begin
            r.words[i]     = pos_st[i];
            r.words[3 + i] = vel_st[i];
            r.words[6 + i] = clamp32(longint'(accel_r[i]) +
                                     ((longint'(frc_st[i]) * iml) >>> pei_pkg::FRAC_BITS));
        end
        if (st == pei_pkg::STS_OK && sat_seen) st = pei_pkg::STS_SAT;
        r.status = st;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_cmd(input pei_pkg::t_opcode op, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] z,
                                      input logic [pei_pkg::DT_W-1:0] dt);
        t_motion_cmd c;
        c.op     = op;
        c.dt     = dt;
        c.vec[0] = x;
        c.vec[1] = y;
        c.vec[2] = z;
        cmd_backlog.push_back(c);
        cmds_sent++;
    endfunction

    // mostly small Q16.16 values, some extremes, some fully random words
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0, 1: return $urandom();
            2: begin
                case ($urandom_range(0, 5))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    4:       return 32'h0001_0000;
                    default: return 32'hFFFF_0000;
                endcase
            end
            default: return $urandom_range(0, 32'h6_0000) - 32'h3_0000;
        endcase
    endfunction

    function automatic logic [pei_pkg::DT_W-1:0] pick_dt();
        case ($urandom_range(0, 19))
            0:       return '0;
            1, 2:    return pei_pkg::DT_W'($urandom());
            3:       return {pei_pkg::DT_W{1'b1}};
            4:       return pei_pkg::DT_W'(1);
            default: return pei_pkg::DT_W'($urandom_range(1, 32'h2_0000));
        endcase
    endfunction

    // two-phase APB write; the shadow copy follows once the access is taken
    task automatic reg_write(input int idx, input logic [31:0] val);
        @(posedge i_clk);
        psel_r    <= 1'b1;
        penable_r <= 1'b0;
        pwrite_r  <= 1'b1;
        paddr_r   <= pei_pkg::ADDR_W'(idx * 4);
        pwdata_r  <= val;
        @(posedge i_clk);
        penable_r <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel_r    <= 1'b0;
        penable_r <= 1'b0;
        pwrite_r  <= 1'b0;
        case (idx)
            pei_pkg::REG_INV_MASS:  inv_mass_r = val[pei_pkg::DT_W-1:0];
            pei_pkg::REG_DAMP_LOG2: damp_r     = val[pei_pkg::DAMP_W-1:0];
            pei_pkg::REG_ACCEL_X:   accel_r[0] = val;
            pei_pkg::REG_ACCEL_Y:   accel_r[1] = val;
            pei_pkg::REG_ACCEL_Z:   accel_r[2] = val;
            default:                ;  // no register there, the block drops it
        endcase
    endtask

    // wait for every result, then let the sequencer settle before new writes
    task automatic drain_results();
        while (results_seen != cmds_sent) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_random();
        logic [31:0] v;
        int          k;
        case ($urandom_range(0, 9))
            0:       v = 32'h0;
            1:       v = 32'h7FFF_FFFF;
            2, 3:    v = $urandom();
            default: v = $urandom_range(1, 32'h4_0000);
        endcase
        v[31] = $urandom_range(0, 1);   // above the field, ignored
        reg_write(pei_pkg::REG_INV_MASS, v);
        case ($urandom_range(0, 9))
            0:       v = 32'h0080_0000;                 // -2^23: damping zero
            1:       v = $urandom_range(1, 24'h7F_FFFF); // positive log
            2, 3:    v = 32'h0;
            4:       v = $urandom();
            default: v = 32'h0100_0000 - $urandom_range(1, 32'h2_0000);
        endcase
        v[31:24] = $urandom_range(0, 255);
        reg_write(pei_pkg::REG_DAMP_LOG2, v);
        for (k = 0; k < 3; k++) reg_write(pei_pkg::REG_ACCEL_X + k, pick_word());
        if ($urandom_range(0, 2) == 0)
            reg_write($urandom_range(REG_SPARE_LO, REG_SPARE_HI), $urandom());
        settings_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // driver: one item held on the input stream until taken; prediction
    // happens at the accepting edge so the model sees items in order
    // ------------------------------------------------------------------------
    t_motion_cmd cur_cmd;
    int          src_gap = 0;

    always @(posedge i_clk) begin : feed_proc
        logic taken;
        logic have;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            taken = s_tvalid && o_s_tready;
            if (taken) begin
                state_reports_due.push_back(predict_motion(cur_cmd));
                cmds_taken++;
            end
            have = s_tvalid && !taken;
            if (!have) begin
                if (src_gap != 0) begin
                    src_gap--;
                end else if (cmd_backlog.size() != 0) begin
                    cur_cmd = cmd_backlog.pop_front();
                    have    = 1'b1;
                    if ($urandom_range(0, 99) < src_gap_pct) src_gap = $urandom_range(1, 9);
                end
            end
            s_tvalid <= have;
            if (have) begin
                s_tdata <= {1'b0, cur_cmd.dt, cur_cmd.vec};
                s_tuser <= cur_cmd.op;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check each taken result against the oldest prediction,
    // tready drops in random bursts
    // ------------------------------------------------------------------------
    int snk_gap = 0;

    always @(posedge i_clk) begin : sink_proc
        t_state_report want;
        logic [31:0]   got;
        int            k;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (state_reports_due.size() == 0) begin
                    $error("result item with no prediction waiting");
                    err_cnt++;
                end else begin
                    want = state_reports_due.pop_front();
                    results_seen++;
                    for (k = 0; k < 9; k++) begin
                        got = o_m_tdata[32*k +: 32];
                        if (got !== want.words[k]) begin
                            $error("%s: expected %0d, actual %0d", word_names[k],
                                   $signed(want.words[k]), $signed(got));
                            err_cnt++;
                        end
                    end
                    if (o_m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_m_tuser);
                        err_cnt++;
                    end
                end
            end
            if (snk_gap != 0) begin
                snk_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < snk_gap_pct) snk_gap = $urandom_range(1, 9);
            end
        end
    end

    // watchdog: any accepted item or register access counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) ||
            (psel_r && penable_r)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------------
    initial begin : main_proc
        logic [63:0] root;
        int          p;
        int          k;
        root = 64'h8000_0000;
        for (k = 0; k < pei_pkg::EXP_TABLE_BITS; k++) begin
            root        = floor_root(root << 30);
            root_tab[k] = root;
        end
        for (k = 0; k < 3; k++) begin
            accel_r[k] = '0;
            pos_st[k]  = '0;
            vel_st[k]  = '0;
            frc_st[k]  = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero inverse mass, so integrate is skipped
        src_gap_pct = 20;
        snk_gap_pct = 20;
        settings_cnt++;
        queue_cmd(pei_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0, 31'h0001_0000);
        queue_cmd(pei_pkg::OP_ADD_FORCE, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 31'h0);
        queue_cmd(pei_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0, 31'h0);
        drain_results();

        // unit mass, no damping: zero step, plain steps, accumulator clamps
        reg_write(pei_pkg::REG_INV_MASS, 32'h0001_0000);
        reg_write(pei_pkg::REG_DAMP_LOG2, 32'h0);
        reg_write(pei_pkg::REG_ACCEL_X, 32'h0001_0000);
        reg_write(pei_pkg::REG_ACCEL_Y, 32'hFFFF_0000);
        reg_write(pei_pkg::REG_ACCEL_Z, 32'h0);
        settings_cnt++;
        queue_cmd(pei_pkg::OP_LOAD_POS, 32'h0, 32'h0, 32'h0, 31'h0);
        queue_cmd(pei_pkg::OP_LOAD_VEL, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 31'h0);
        queue_cmd(pei_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0, 31'h0);
        queue_cmd(pei_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0, 31'h0001_0000);
        queue_cmd(pei_pkg::OP_ADD_FORCE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0);
        queue_cmd(pei_pkg::OP_ADD_FORCE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0);
        queue_cmd(pei_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0, 31'h0000_8000);
        queue_cmd(pei_pkg::OP_LOAD_POS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                  {pei_pkg::DT_W{1'b1}});
        queue_cmd(pei_pkg::OP_LOAD_VEL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h0);
        queue_cmd(pei_pkg::OP_INTEGRATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  {pei_pkg::DT_W{1'b1}});
        queue_cmd(pei_pkg::OP_ADD_FORCE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0);
        drain_results();

        // largest mass inverse, damping zero, extreme base acceleration,
        // plus writes to addresses with no register behind them
        reg_write(pei_pkg::REG_INV_MASS, 32'hFFFF_FFFF);
        reg_write(pei_pkg::REG_DAMP_LOG2, 32'h0080_0000);
        reg_write(pei_pkg::REG_ACCEL_X, 32'h7FFF_FFFF);
        reg_write(pei_pkg::REG_ACCEL_Y, 32'h8000_0000);
        reg_write(pei_pkg::REG_ACCEL_Z, 32'h7FFF_FFFF);
        for (k = REG_SPARE_LO; k <= REG_SPARE_HI; k++) reg_write(k, $urandom());
        settings_cnt++;
        queue_cmd(pei_pkg::OP_ADD_FORCE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 31'h0);
        queue_cmd(pei_pkg::OP_LOAD_VEL, 32'h0001_0000, 32'h0003_0000, 32'hFFF0_0000, 31'h0);
        queue_cmd(pei_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0, 31'h0001_0000);
        queue_cmd(pei_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0, {pei_pkg::DT_W{1'b1}});
        drain_results();

        // positive log damping clips to a factor of one
        reg_write(pei_pkg::REG_INV_MASS, 32'h0000_0001);
        reg_write(pei_pkg::REG_DAMP_LOG2, 32'h007F_FFFF);
        reg_write(pei_pkg::REG_ACCEL_X, 32'h0);
        reg_write(pei_pkg::REG_ACCEL_Y, 32'h0);
        reg_write(pei_pkg::REG_ACCEL_Z, 32'h0);
        settings_cnt++;
        queue_cmd(pei_pkg::OP_LOAD_VEL, 32'h0005_0000, 32'hFFFB_0000, 32'h0000_1234, 31'h0);
        queue_cmd(pei_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0, 31'h0001_0000);
        drain_results();

        // halving per unit time, then a step long enough to wipe velocity
        reg_write(pei_pkg::REG_DAMP_LOG2, 32'h00FF_0000);
        settings_cnt++;
        queue_cmd(pei_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0, 31'h0001_8000);
        queue_cmd(pei_pkg::OP_INTEGRATE, 32'h0, 32'h0, 32'h0, {pei_pkg::DT_W{1'b1}});
        drain_results();

        // random phases: well-formed load / force / integrate runs with some
        // noise; the sender pauses at each boundary until all results are in
        for (p = 0; p < RAND_PHASES; p++) begin
            program_random();
            if (p == RAND_PHASES - 1) begin
                src_gap_pct = 0;
                snk_gap_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       src_gap_pct = 0;
                    1:       src_gap_pct = 10;
                    default: src_gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0:       snk_gap_pct = 0;
                    1:       snk_gap_pct = 10;
                    default: snk_gap_pct = 35;
                endcase
            end
            k = cmds_sent + PHASE_ITEMS;
            while (cmds_sent < k) begin
                if ($urandom_range(0, 99) < 15) begin
                    queue_cmd(pei_pkg::t_opcode'($urandom_range(0, 3)), $urandom(),
                              $urandom(), $urandom(), pei_pkg::DT_W'($urandom()));
                end else begin
                    if ($urandom_range(0, 1))
                        queue_cmd(pei_pkg::OP_LOAD_POS, pick_word(), pick_word(),
                                  pick_word(), pick_dt());
                    if ($urandom_range(0, 1))
                        queue_cmd(pei_pkg::OP_LOAD_VEL, pick_word(), pick_word(),
                                  pick_word(), pick_dt());
                    repeat ($urandom_range(0, 3))
                        queue_cmd(pei_pkg::OP_ADD_FORCE, pick_word(), pick_word(),
                                  pick_word(), pick_dt());
                    repeat ($urandom_range(1, 3))
                        queue_cmd(pei_pkg::OP_INTEGRATE, pick_word(), pick_word(),
                                  pick_word(), pick_dt());
                end
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (state_reports_due.size() != 0) begin
            $error("%0d predicted results never arrived", state_reports_due.size());
            err_cnt++;
        end
        $display("covered %0d items under %0d register settings, %0d results checked",
                 cmds_taken, settings_cnt, results_seen);
        $display("incl. static body, zero step, zero and clipped damping, saturation");
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/pei_pkg.sv
hw/rtl/pei_lane.sv
hw/rtl/pei_damp.sv
hw/rtl/pei_merge.sv
hw/rtl/particle_euler_integrator_top.sv
hw/rtl/pei_checker.sv
tb/tb_top.sv
